FILE: hw/rtl/recurrent_event_concordance_unit_assert.svh
// ----------------------------------------------------------------------------
// recurrent event concordance unit assertion macros
// concurrent check wrappers, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef RECURRENT_EVENT_CONCORDANCE_UNIT_ASSERT_SVH
`define RECURRENT_EVENT_CONCORDANCE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RECU_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("recu check failed");
`define RECU_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("recu check failed");
`else
`define RECU_ASSERT(label, prop)
`define RECU_ASSERT_NEXT(label, cond, prop)
`endif
`endif

FILE: hw/rtl/recu_pkg.sv
// ----------------------------------------------------------------------------
// recu_pkg
// shared constants and codes of the recurrent event concordance unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package recu_pkg;
	localparam int MAX_SUBJECTS_DEF = 256;
	localparam int MAX_EVENTS_DEF   = 4096;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int VAL_W            = 32;
	localparam int OUT_W            = 48;

	localparam logic [1:0] KIND_SUBJECT = 2'd0;
	localparam logic [1:0] KIND_EVENT   = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FEW     = 2'd1;
	localparam logic [1:0] STATUS_DROPPED = 2'd2;
endpackage

FILE: hw/rtl/recurrent_event_concordance_unit.sv
// ----------------------------------------------------------------------------
// recurrent_event_concordance_unit
// event count and event pair concordance over all loaded subject pairs
// ----------------------------------------------------------------------------
// Load beats (subject record, event time) are taken one per cycle while idle.
// A compute beat walks every subject pair through a single time-store read
// port: it reads both subject records, counts each subject's events inside the
// partner's follow-up and, when the scores differ, compares every event of
// subject i inside j's follow-up with every event of j inside i's follow-up.
// Both sums then go through one shared restoring divider, one quotient bit a
// cycle, for NUM_W = 2*(clog2(MAX_EVENTS)+1) + clog2(MAX_SUBJECTS) + 2 +
// FRAC_BITS + 2 quotient bits. The slave side is not ready while a compute
// beat runs; the result waits in an output register, loads may follow at once.
`timescale 1ns / 1ps
`include "recurrent_event_concordance_unit_assert.svh"
module recurrent_event_concordance_unit import recu_pkg::*; #(
	parameter int MAX_SUBJECTS = MAX_SUBJECTS_DEF,
	parameter int MAX_EVENTS   = MAX_EVENTS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // covariate_score, follow_up_end, event_time
	input  logic [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // first_stat, second_stat
	output logic [1:0]  m_tuser   // status
);
	localparam int SW    = $clog2(MAX_SUBJECTS);
	localparam int NW    = SW + 1;
	localparam int EW    = $clog2(MAX_EVENTS);
	localparam int CW    = EW + 1;
	localparam int SUM_W = 2 * CW + NW + 1;
	localparam int DEN_W = 2 * NW;
	localparam int NUM_W = SUM_W + FRAC_BITS + 2;
	localparam int DCW   = $clog2(NUM_W + 1);
	localparam int SAT_W = (NUM_W > OUT_W) ? NUM_W : OUT_W;
	localparam logic [SAT_W-1:0] POS_LIM = SAT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(64'd1 << (OUT_W - 1));

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_RD_I    = 18'h00002,
		S_RD_J    = 18'h00004,
		S_LAT_J   = 18'h00008,
		S_C1_RD   = 18'h00010,
		S_C1_CHK  = 18'h00020,
		S_C2_RD   = 18'h00040,
		S_C2_CHK  = 18'h00080,
		S_ACC1    = 18'h00100,
		S_PA_RD   = 18'h00200,
		S_PA_CHK  = 18'h00400,
		S_PB_RD   = 18'h00800,
		S_PB_CHK  = 18'h01000,
		S_NEXT    = 18'h02000,
		S_DEN     = 18'h04000,
		S_DIV_LD  = 18'h08000,
		S_DIV_RUN = 18'h10000,
		S_FIN     = 18'h20000
	} state_t;

	state_t state_q;

	logic signed [VAL_W-1:0] score_mem [MAX_SUBJECTS];
	logic [VAL_W-1:0]        end_mem   [MAX_SUBJECTS];
	logic [EW-1:0]           first_mem [MAX_SUBJECTS];
	logic [CW-1:0]           cnt_mem   [MAX_SUBJECTS];
	logic [VAL_W-1:0]        time_mem  [MAX_EVENTS];

	logic signed [VAL_W-1:0] sc_rd_q;
	logic [VAL_W-1:0]        end_rd_q, t_rd_q;
	logic [EW-1:0]           first_rd_q;
	logic [CW-1:0]           cnt_rd_q;

	logic [NW-1:0] subj_cnt_q, subj_last;
	logic [CW-1:0] evt_cnt_q, cur_cnt_q;
	logic          dropped_q;

	logic [SW-1:0] i_q, j_q, subj_raddr, cnt_waddr;
	logic [CW-1:0] k_q, l_q, c1_q, c2_q, cnt_wdata, cnt_i_q, cnt_j_q;
	logic [EW-1:0] first_i_q, first_j_q, t_raddr;
	logic signed [VAL_W-1:0] sc_i_q;
	logic [VAL_W-1:0] end_i_q, end_j_q, ta_q;
	logic ds_pos_q, ds_neg_q;
	logic signed [SUM_W-1:0] s1_q, s2_q, s_sel;
	logic signed [CW:0] diff;
	logic [SUM_W-1:0] mag;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q, trial;
	logic [NUM_W-1:0] quo_q;
	logic [DCW-1:0]   dcnt_q;
	logic             sel_q, neg_q;
	logic [SAT_W-1:0] q_ext, q_sat;
	logic [OUT_W-1:0] q_out;
	logic [OUT_W-1:0] res1_q, res2_q, out1_q, out2_q;
	logic [1:0]       status_q, out_status_q;
	logic             m_tvalid_q;

	logic accept, subj_ok, evt_ok, subj_wr, evt_wr, cnt_wr, drop, out_load;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign subj_ok  = subj_cnt_q < NW'(MAX_SUBJECTS);
	assign evt_ok   = (subj_cnt_q != '0) && (evt_cnt_q < CW'(MAX_EVENTS));
	assign subj_wr  = accept && (s_tuser == KIND_SUBJECT) && subj_ok;
	assign evt_wr   = accept && (s_tuser == KIND_EVENT) && evt_ok;
	assign cnt_wr   = subj_wr | evt_wr;
	assign drop     = accept && (((s_tuser == KIND_SUBJECT) && !subj_ok) ||
		((s_tuser == KIND_EVENT) && !evt_ok));
	assign subj_last = subj_cnt_q - NW'(1);
	assign cnt_waddr = subj_wr ? subj_cnt_q[SW-1:0] : subj_last[SW-1:0];
	assign cnt_wdata = subj_wr ? '0 : cur_cnt_q + CW'(1);
	assign out_load  = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	assign subj_raddr = (state_q == S_RD_J) ? j_q : i_q;

	always_comb begin
		unique case (state_q)
			S_C1_RD, S_PA_RD: t_raddr = first_i_q + k_q[EW-1:0];
			S_C2_RD, S_PB_RD: t_raddr = first_j_q + l_q[EW-1:0];
			default:          t_raddr = '0;
		endcase
	end

	assign diff  = $signed({1'b0, c1_q}) - $signed({1'b0, c2_q});
	assign s_sel = sel_q ? s2_q : s1_q;
	assign mag   = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
	assign trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign q_ext = SAT_W'(quo_q);

	always_comb begin
		q_sat = q_ext;
		if (!neg_q && q_ext > POS_LIM) begin
			q_sat = POS_LIM;
		end
		if (neg_q && q_ext > NEG_LIM) begin
			q_sat = NEG_LIM;
		end
		q_out = neg_q ? OUT_W'(-q_sat[OUT_W-1:0]) : q_sat[OUT_W-1:0];
	end

	// stores
	always_ff @(posedge clk) begin
		if (subj_wr) begin
			score_mem[subj_cnt_q[SW-1:0]] <= s_tdata[31:0];
			end_mem[subj_cnt_q[SW-1:0]]   <= s_tdata[63:32];
			first_mem[subj_cnt_q[SW-1:0]] <= evt_cnt_q[EW-1:0];
		end
		if (cnt_wr) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (evt_wr) begin
			time_mem[evt_cnt_q[EW-1:0]] <= s_tdata[95:64];
		end
		sc_rd_q    <= score_mem[subj_raddr];
		end_rd_q   <= end_mem[subj_raddr];
		first_rd_q <= first_mem[subj_raddr];
		cnt_rd_q   <= cnt_mem[subj_raddr];
		t_rd_q     <= time_mem[t_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			subj_cnt_q   <= '0;
			evt_cnt_q    <= '0;
			cur_cnt_q    <= '0;
			dropped_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			l_q          <= '0;
			c1_q         <= '0;
			c2_q         <= '0;
			first_i_q    <= '0;
			first_j_q    <= '0;
			cnt_i_q      <= '0;
			cnt_j_q      <= '0;
			sc_i_q       <= '0;
			end_i_q      <= '0;
			end_j_q      <= '0;
			ta_q         <= '0;
			ds_pos_q     <= 1'b0;
			ds_neg_q     <= 1'b0;
			s1_q         <= '0;
			s2_q         <= '0;
			den_q        <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			dcnt_q       <= '0;
			sel_q        <= 1'b0;
			neg_q        <= 1'b0;
			res1_q       <= '0;
			res2_q       <= '0;
			status_q     <= STATUS_OK;
			out1_q       <= '0;
			out2_q       <= '0;
			out_status_q <= STATUS_OK;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (subj_wr) begin
				subj_cnt_q <= subj_cnt_q + NW'(1);
				cur_cnt_q  <= '0;
			end
			if (evt_wr) begin
				evt_cnt_q <= evt_cnt_q + CW'(1);
				cur_cnt_q <= cur_cnt_q + CW'(1);
			end
			if (drop) begin
				dropped_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && s_tuser == KIND_COMPUTE) begin
						s1_q <= '0;
						s2_q <= '0;
						i_q  <= '0;
						j_q  <= SW'(1);
						if (subj_cnt_q < NW'(2)) begin
							res1_q   <= '0;
							res2_q   <= '0;
							status_q <= STATUS_FEW;
							state_q  <= S_FIN;
						end else begin
							status_q <= dropped_q ? STATUS_DROPPED : STATUS_OK;
							state_q  <= S_RD_I;
						end
					end
				end
				S_RD_I: state_q <= S_RD_J;
				S_RD_J: begin
					sc_i_q    <= sc_rd_q;
					end_i_q   <= end_rd_q;
					first_i_q <= first_rd_q;
					cnt_i_q   <= cnt_rd_q;
					state_q   <= S_LAT_J;
				end
				S_LAT_J: begin
					end_j_q   <= end_rd_q;
					first_j_q <= first_rd_q;
					cnt_j_q   <= cnt_rd_q;
					ds_pos_q  <= sc_i_q > sc_rd_q;
					ds_neg_q  <= sc_i_q < sc_rd_q;
					k_q       <= '0;
					l_q       <= '0;
					c1_q      <= '0;
					c2_q      <= '0;
					state_q   <= S_C1_RD;
				end
				S_C1_RD: state_q <= (k_q < cnt_i_q) ? S_C1_CHK : S_C2_RD;
				S_C1_CHK: begin
					if (t_rd_q <= end_j_q) begin
						c1_q <= c1_q + CW'(1);
					end
					k_q     <= k_q + CW'(1);
					state_q <= S_C1_RD;
				end
				S_C2_RD: state_q <= (l_q < cnt_j_q) ? S_C2_CHK : S_ACC1;
				S_C2_CHK: begin
					if (t_rd_q <= end_i_q) begin
						c2_q <= c2_q + CW'(1);
					end
					l_q     <= l_q + CW'(1);
					state_q <= S_C2_RD;
				end
				S_ACC1: begin
					if (ds_pos_q) begin
						s1_q <= s1_q + SUM_W'(diff);
					end else if (ds_neg_q) begin
						s1_q <= s1_q - SUM_W'(diff);
					end
					k_q     <= '0;
					state_q <= (ds_pos_q || ds_neg_q) ? S_PA_RD : S_NEXT;
				end
				S_PA_RD: state_q <= (k_q < cnt_i_q) ? S_PA_CHK : S_NEXT;
				S_PA_CHK: begin
					if (t_rd_q <= end_j_q) begin
						ta_q    <= t_rd_q;
						l_q     <= '0;
						state_q <= S_PB_RD;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_PA_RD;
					end
				end
				S_PB_RD: begin
					if (l_q < cnt_j_q) begin
						state_q <= S_PB_CHK;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_PA_RD;
					end
				end
				S_PB_CHK: begin
					if (t_rd_q <= end_i_q && t_rd_q != ta_q) begin
						if ((ta_q > t_rd_q) == ds_pos_q) begin
							s2_q <= s2_q + SUM_W'(1);
						end else begin
							s2_q <= s2_q - SUM_W'(1);
						end
					end
					l_q     <= l_q + CW'(1);
					state_q <= S_PB_RD;
				end
				S_NEXT: begin
					if (({1'b0, j_q} + NW'(1)) < subj_cnt_q) begin
						j_q     <= j_q + SW'(1);
						state_q <= S_RD_I;
					end else if (({1'b0, i_q} + NW'(2)) < subj_cnt_q) begin
						i_q     <= i_q + SW'(1);
						j_q     <= i_q + SW'(2);
						state_q <= S_RD_I;
					end else begin
						state_q <= S_DEN;
					end
				end
				S_DEN: begin
					den_q   <= DEN_W'(subj_cnt_q) * DEN_W'(subj_last);
					sel_q   <= 1'b0;
					state_q <= S_DIV_LD;
				end
				S_DIV_LD: begin
					neg_q   <= s_sel[SUM_W-1];
					quo_q   <= (NUM_W'(mag) << (FRAC_BITS + 1)) + NUM_W'(den_q >> 1);
					rem_q   <= '0;
					dcnt_q  <= DCW'(NUM_W);
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					if (dcnt_q != '0) begin
						if (trial >= {1'b0, den_q}) begin
							rem_q <= trial - {1'b0, den_q};
							quo_q <= {quo_q[NUM_W-2:0], 1'b1};
						end else begin
							rem_q <= trial;
							quo_q <= {quo_q[NUM_W-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q - DCW'(1);
					end else if (!sel_q) begin
						res1_q  <= q_out;
						sel_q   <= 1'b1;
						state_q <= S_DIV_LD;
					end else begin
						res2_q  <= q_out;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						out1_q       <= res1_q;
						out2_q       <= res2_q;
						out_status_q <= status_q;
						subj_cnt_q   <= '0;
						evt_cnt_q    <= '0;
						cur_cnt_q    <= '0;
						dropped_q    <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out2_q, out1_q};
	assign m_tuser  = out_status_q;

	`RECU_ASSERT(a_subj_bound, subj_cnt_q <= NW'(MAX_SUBJECTS))
	`RECU_ASSERT(a_evt_bound, evt_cnt_q <= CW'(MAX_EVENTS))
	`RECU_ASSERT(a_div_bound, dcnt_q <= DCW'(NUM_W))
	`RECU_ASSERT_NEXT(a_clear_after_emit, out_load, subj_cnt_q == '0 && !dropped_q && m_tvalid)
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recurrent event concordance unit testbench
// loads subjects and event times, runs compute beats and checks both scaled
// concordance sums and the status against a cycle-free predictor
// ----------------------------------------------------------------------------
module testbench;
	import recu_pkg::*;

	localparam int  N_SUBJ     = MAX_SUBJECTS_DEF;
	localparam int  N_EVT      = MAX_EVENTS_DEF;
	localparam int  FRAC       = FRAC_BITS_DEF;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] score;
		logic [31:0] fend;
		logic [31:0] etime;
	} load_beat_t;

	typedef struct packed {
		logic [47:0] first_stat;
		logic [47:0] second_stat;
		logic [1:0]  status;
	} concordance_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;

	recurrent_event_concordance_unit u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	load_beat_t   pending_beats[$];
	concordance_t expected_stats[$];

	// predictor state
	logic signed [31:0] subj_score[N_SUBJ];
	logic [31:0]        subj_end[N_SUBJ];
	int                 subj_first[N_SUBJ];
	int                 subj_count[N_SUBJ];
	logic [31:0]        event_times[N_EVT];
	int                 n_subjects = 0;
	int                 n_events = 0;
	bit                 load_dropped = 0;

	int     n_mismatch = 0;
	int     n_results = 0;
	int     n_computes = 0;
	longint cycle = 0;
	bit     beat_taken = 0;
	int     burst_left = 0;
	int     gap_left = 0;

	function automatic int sgn(longint d);
		return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
	endfunction

	function automatic logic [47:0] scale_q16(longint s, longint unsigned den);
		bit neg;
		longint unsigned mag, q;
		neg = s < 0;
		mag = neg ? -s : s;
		q = ((mag << (FRAC + 1)) + den / 2) / den;
		if (!neg && q > 64'h7FFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF;
		if (neg && q > 64'h8000_0000_0000) q = 64'h8000_0000_0000;
		return neg ? 48'(-q) : 48'(q);
	endfunction

	task automatic apply_beat(load_beat_t b);
		concordance_t r;
		longint s1, s2, c1, c2;
		int ds;
		logic [31:0] ta, tb;
		case (b.kind)
			KIND_SUBJECT: begin
				if (n_subjects >= N_SUBJ) begin
					load_dropped = 1;
				end else begin
					subj_score[n_subjects] = b.score;
					subj_end[n_subjects] = b.fend;
					subj_first[n_subjects] = n_events;
					subj_count[n_subjects] = 0;
					n_subjects++;
				end
			end
			KIND_EVENT: begin
				if (n_subjects == 0 || n_events >= N_EVT) begin
					load_dropped = 1;
				end else begin
					event_times[n_events] = b.etime;
					subj_count[n_subjects - 1]++;
					n_events++;
				end
			end
			KIND_COMPUTE: begin
				n_computes++;
				if (n_subjects < 2) begin
					r = '{48'd0, 48'd0, STATUS_FEW};
				end else begin
					s1 = 0;
					s2 = 0;
					for (int i = 0; i < n_subjects - 1; i++) begin
						for (int j = i + 1; j < n_subjects; j++) begin
							ds = sgn(longint'(subj_score[i]) - longint'(subj_score[j]));
							c1 = 0;
							c2 = 0;
							for (int k = 0; k < subj_count[i]; k++)
								if (event_times[subj_first[i] + k] <= subj_end[j]) c1++;
							for (int l = 0; l < subj_count[j]; l++)
								if (event_times[subj_first[j] + l] <= subj_end[i]) c2++;
							s1 += ds * (c1 - c2);
							if (ds != 0) begin
								for (int k = 0; k < subj_count[i]; k++) begin
									ta = event_times[subj_first[i] + k];
									if (ta <= subj_end[j]) begin
										for (int l = 0; l < subj_count[j]; l++) begin
											tb = event_times[subj_first[j] + l];
											if (tb <= subj_end[i])
												s2 += ds * sgn(longint'(ta) - longint'(tb));
										end
									end
								end
							end
						end
					end
					r.first_stat = scale_q16(s1, longint'(n_subjects) * (n_subjects - 1));
					r.second_stat = scale_q16(s2, longint'(n_subjects) * (n_subjects - 1));
					r.status = load_dropped ? STATUS_DROPPED : STATUS_OK;
				end
				expected_stats.push_back(r);
				n_subjects = 0;
				n_events = 0;
				load_dropped = 0;
			end
			default: ;
		endcase
	endtask

	// stimulus helpers
	function automatic void push_subject(logic [31:0] score, logic [31:0] fend);
		pending_beats.push_back('{KIND_SUBJECT, score, fend, $urandom});
	endfunction

	function automatic void push_event(logic [31:0] t);
		pending_beats.push_back('{KIND_EVENT, $urandom, $urandom, t});
	endfunction

	function automatic void push_kind(logic [1:0] k);
		pending_beats.push_back('{k, $urandom, $urandom, $urandom});
	endfunction

	function automatic logic [31:0] rand_time();
		return ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 40);
	endfunction

	function automatic logic [31:0] rand_score();
		return ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3);
	endfunction

	// input side: bursts with random gaps, calm stretches with none
	always @(negedge clk) begin
		load_beat_t b;
		if (arst_n && (!s_tvalid || beat_taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				b = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {b.etime, b.fend, b.score};
				s_tuser <= b.kind;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ((cycle / 5000) % 3 == 0) ? 0 : $urandom_range(0, 5);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		if (arst_n)
			m_tready <= ((cycle / 3000) % 3 == 0) ? 1'b1 :
				((cycle / 3000) % 3 == 1) ? ((cycle * 7) % 11 > 3) : $urandom_range(0, 1);
	end

	// predict on accepted input beats, check accepted result beats
	always @(posedge clk) begin
		concordance_t want;
		cycle <= cycle + 1;
		beat_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			apply_beat('{s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]});
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (expected_stats.size() == 0) begin
				$error("result beat with no expectation pending");
				n_mismatch++;
			end else begin
				want = expected_stats.pop_front();
				if (m_tdata[47:0] !== want.first_stat) begin
					$error("first_stat expected %h got %h", want.first_stat, m_tdata[47:0]);
					n_mismatch++;
				end
				if (m_tdata[95:48] !== want.second_stat) begin
					$error("second_stat expected %h got %h", want.second_stat, m_tdata[95:48]);
					n_mismatch++;
				end
				if (m_tuser !== want.status) begin
					$error("status expected %0d got %0d", want.status, m_tuser);
					n_mismatch++;
				end
			end
		end
		if (cycle >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int n_items, n_subj, n_ev;
		// directed: empty compute, orphan event, extremes, ties, unused kind
		push_kind(KIND_COMPUTE);
		push_event(32'd5);
		push_subject(32'd1, 32'd9);
		push_kind(KIND_COMPUTE);
		push_subject(32'h8000_0000, 32'hFFFF_FFFF);
		push_event(32'd0);
		push_event(32'hFFFF_FFFF);
		push_event(32'd7);
		push_subject(32'h7FFF_FFFF, 32'd0);
		push_event(32'd0);
		push_event(32'd7);
		push_kind(KIND_UNUSED);
		push_subject(32'd0, 32'd7);
		push_event(32'd7);
		push_subject(32'd0, 32'd100);
		push_event(32'd3);
		push_kind(KIND_COMPUTE);
		push_event(32'd1);
		push_subject(32'd4, 32'd10);
		push_event(32'd2);
		push_subject(32'd2, 32'd10);
		push_event(32'd1);
		push_kind(KIND_COMPUTE);
		// subject store overflow
		for (int i = 0; i <= N_SUBJ; i++) begin
			push_subject(rand_score(), rand_time());
			if (i < 3) push_event(rand_time());
		end
		push_kind(KIND_COMPUTE);
		// random sets of subjects with noise
		n_items = 0;
		while (n_items < 665) begin
			n_subj = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
			if ($urandom_range(0, 9) == 0) begin
				push_event(rand_time());
				n_items++;
			end
			for (int s = 0; s < n_subj; s++) begin
				push_subject(rand_score(), rand_time());
				n_ev = $urandom_range(0, 4);
				for (int e = 0; e < n_ev; e++) push_event(rand_time());
				n_items += 1 + n_ev;
				if ($urandom_range(0, 19) == 0) push_kind(KIND_UNUSED);
			end
			push_kind(KIND_COMPUTE);
			n_items++;
		end
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		wait (pending_beats.size() == 0 && !s_tvalid && expected_stats.size() == 0);
		repeat (300) @(posedge clk);
		$display("ran %0d compute beats with %0d results checked, including a subject store overflow",
			n_computes, n_results);
		if (n_mismatch == 0 && expected_stats.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/recu_pkg.sv
hw/rtl/recurrent_event_concordance_unit.sv
tb/testbench.sv
